@@ hw/rtl/cput_pkg.sv @@
// Shared types and constants for the code page to Unicode translation table.
package cput_pkg;

	localparam int TableEntries = 128;
	localparam int IdxW = $clog2(TableEntries);
	localparam int CntW = IdxW + 1;
	localparam int KeyW = 16;
	localparam int CodeW = 8;
	localparam int GroupSize = 8;
	localparam int Groups = TableEntries / GroupSize;
	localparam int InW = 40;
	localparam int OutW = 32;
	localparam logic [CodeW-1:0] CodeBase = 8'h80;
	localparam logic [1:0] ResultCycle = 2'd2;

	typedef enum logic [1:0] {
		OP_LOAD     = 2'd0,
		OP_TO_UNI   = 2'd1,
		OP_TO_LOWER = 2'd2,
		OP_TO_CODE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NOT_FOUND  = 2'd1,
		ST_NOT_LOADED = 2'd2,
		ST_ORDER      = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_WAIT
	} state_t;

	typedef struct packed {
		logic [KeyW-1:0] key;
		logic [IdxW-1:0] code;
	} rev_entry_t;

	typedef struct packed {
		logic       gt;
		rev_entry_t ent;
	} link_t;

	typedef struct packed {
		logic            hit;
		logic [IdxW-1:0] code;
	} hit_t;

endpackage

@@ hw/rtl/cput_cell.sv @@
// One cell of the sorted reverse table: holds an entry, shifts on insert, compares on search.
module cput_cell (
	input  logic               clk,
	input  logic               load_en,
	input  logic               search_en,
	input  logic               occ,
	input  logic               first_free,
	input  cput_pkg::rev_entry_t new_ent,
	input  logic [cput_pkg::KeyW-1:0] query,
	input  cput_pkg::link_t    left,
	output cput_pkg::link_t    right,
	input  logic               match_next,
	output logic               match,
	output cput_pkg::hit_t     hit
);
	import cput_pkg::*;

	rev_entry_t ent_q;
	logic       match_s1;
	logic       gt;
	logic       last_match;

	assign gt = occ & (ent_q.key > new_ent.key);
	assign right = '{gt: gt, ent: ent_q};
	assign match = match_s1;

	// Equal keys are contiguous, so only the last cell of a run of matches flags a hit.
	assign last_match = match_s1 & ~match_next;
	assign hit = '{hit: last_match, code: last_match ? ent_q.code : '0};

	always_ff @(posedge clk) begin
		if (load_en && (gt || first_free)) begin
			ent_q <= left.gt ? left.ent : new_ent;
		end
		if (search_en) begin
			match_s1 <= (ent_q.key == query);
		end
	end

endmodule

@@ hw/rtl/cput_chain.sv @@
// Row of reverse table cells with the registered reduction of their hit flags.
module cput_chain (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load_en,
	input  logic                      search_en,
	input  logic [cput_pkg::CntW-1:0] count,
	input  logic [cput_pkg::KeyW-1:0] key_in,
	output cput_pkg::hit_t            result
);
	import cput_pkg::*;

	link_t      links [TableEntries+1];
	logic       match_vec [TableEntries+1];
	hit_t       hits [TableEntries];
	hit_t       grp_s2 [Groups];
	hit_t       res_s3;
	rev_entry_t new_ent;
	hit_t       grp_or [Groups];
	hit_t       res_or;

	assign new_ent = '{key: key_in, code: count[IdxW-1:0]};
	assign links[0] = '0;
	assign match_vec[TableEntries] = 1'b0;

	for (genvar i = 0; i < TableEntries; i++) begin : g_cell
		cput_cell u_cell (
			.clk        (clk),
			.load_en    (load_en),
			.search_en  (search_en),
			.occ        (count > CntW'(i)),
			.first_free (count == CntW'(i)),
			.new_ent    (new_ent),
			.query      (key_in),
			.left       (links[i]),
			.right      (links[i+1]),
			.match_next (match_vec[i+1]),
			.match      (match_vec[i]),
			.hit        (hits[i])
		);
	end

	always_comb begin
		for (int g = 0; g < Groups; g++) begin
			grp_or[g] = '0;
			for (int j = 0; j < GroupSize; j++) begin
				grp_or[g] = grp_or[g] | hits[g*GroupSize+j];
			end
		end
		res_or = '0;
		for (int g = 0; g < Groups; g++) begin
			res_or = res_or | grp_s2[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s3 <= '0;
			for (int g = 0; g < Groups; g++) begin
				grp_s2[g] <= '0;
			end
		end else begin
			res_s3 <= res_or;
			for (int g = 0; g < Groups; g++) begin
				grp_s2[g] <= grp_or[g];
			end
		end
	end

	assign result = res_s3;

endmodule

@@ hw/rtl/codepage_unicode_translation_table_unit.sv @@
// Top level of the code page to Unicode translation table.
//
// Requests enter on the s_tvalid/s_tready/s_tdata stream and each one yields exactly
// one response on the m_tvalid/m_tready/m_tdata stream. A request is a load of the
// next code (codes 0x80 to 0xFF in order), a code to Unicode lookup, a code to
// lower-case lookup, or a Unicode to code search.
// After acceptance the cell row compares all 128 reverse entries against the key
// into the cell match registers, and a two-level registered OR tree (group OR
// registers, then the result register) collapses the single hit. The response is
// registered once that result is ready and the output register is free; a load
// inserts into the sorted row in the accepting edge. Only one request is in flight
// at a time: s_tready stays low until the response has been registered.
// If the receiver stalls, the held response stays on m_tdata and a finished request
// waits for the output register to drain before s_tready rises again.
// Reset clears the load count, the control state and the output valid; the table
// contents are undefined until loaded, and lookups answer "not loaded" until all
// 128 codes are in.
module codepage_unicode_translation_table_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// op[1:0], code[9:2], unicode_value[25:10], lower_code[33:26], zero fill.
	input  logic [cput_pkg::InW-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// unicode_out[15:0], code_out[23:16], status[25:24], zero fill.
	output logic [cput_pkg::OutW-1:0] m_tdata
);
	import cput_pkg::*;

	logic [KeyW-1:0]  fwd_mem [TableEntries];
	logic [CodeW-1:0] low_mem [TableEntries];
	logic [KeyW-1:0]  fwd_rd_q;
	logic [CodeW-1:0] low_rd_q;

	state_t          state_q, state_d;
	logic [1:0]      cnt_q;
	logic [CntW-1:0] count_q;
	op_t             op_q;
	status_t         status_q;
	logic            out_valid_q;
	logic [OutW-1:0] out_data_q;

	op_t             in_op;
	logic [CodeW-1:0] in_code;
	logic [KeyW-1:0]  in_uval;
	logic [CodeW-1:0] in_lower;
	logic             accept;
	logic             full;
	logic             load_ok;
	logic             finish;
	status_t          status_in;
	status_t          status_fin;
	hit_t             result;
	logic [KeyW-1:0]  uni_fin;
	logic [CodeW-1:0] code_fin;

	assign in_op    = op_t'(s_tdata[1:0]);
	assign in_code  = s_tdata[9:2];
	assign in_uval  = s_tdata[25:10];
	assign in_lower = s_tdata[33:26];

	assign full    = count_q[CntW-1];
	assign accept  = s_tvalid & s_tready;
	assign load_ok = !full && (in_code == (CodeBase + CodeW'(count_q[IdxW-1:0])));

	always_comb begin
		if (in_op == OP_LOAD) begin
			status_in = load_ok ? ST_OK : ST_ORDER;
		end else begin
			status_in = full ? ST_OK : ST_NOT_LOADED;
		end
	end

	cput_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.load_en   (accept && in_op == OP_LOAD && load_ok),
		.search_en (accept),
		.count     (count_q),
		.key_in    (in_uval),
		.result    (result)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			if (in_op == OP_LOAD && load_ok) begin
				fwd_mem[in_code[IdxW-1:0]] <= in_uval;
				low_mem[in_code[IdxW-1:0]] <= in_lower;
			end else begin
				fwd_rd_q <= fwd_mem[in_code[IdxW-1:0]];
				low_rd_q <= low_mem[in_code[IdxW-1:0]];
			end
		end
	end

	always_comb begin
		status_fin = status_q;
		uni_fin    = '0;
		code_fin   = '0;
		if (status_q == ST_OK) begin
			unique case (op_q)
				OP_TO_UNI:   uni_fin = fwd_rd_q;
				OP_TO_LOWER: code_fin = low_rd_q;
				OP_TO_CODE: begin
					if (result.hit) begin
						code_fin = CodeBase | CodeW'(result.code);
					end else begin
						status_fin = ST_NOT_FOUND;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		finish   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = S_WAIT;
				end
			end
			S_WAIT: begin
				if (cnt_q == ResultCycle && (!out_valid_q || m_tready)) begin
					finish  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			count_q     <= '0;
			op_q        <= OP_LOAD;
			status_q    <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q    <= '0;
				op_q     <= in_op;
				status_q <= status_in;
				if (in_op == OP_LOAD && load_ok) begin
					count_q <= count_q + 1'b1;
				end
			end else if (state_q == S_WAIT && cnt_q != ResultCycle) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_data_q <= {6'd0, status_fin, code_fin, uni_fin};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

@@ hw/rtl/cput_checker.sv @@
// Port-level checker for the translation table unit and its bind statement.
module cput_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [cput_pkg::OutW-1:0] m_tdata
);
	import cput_pkg::*;

	// A held response stays valid until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("response dropped while stalled");

	// Only one request is in flight at a time.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while another is in flight");

	// A Unicode value is only returned with an ok status.
	a_uni: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[15:0] != 16'd0 |-> m_tdata[25:24] == ST_OK)
		else $error("unicode value with failing status");

	// Failing responses carry no code.
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[25:24] != ST_OK |-> m_tdata[23:16] == 8'd0)
		else $error("code value with failing status");

endmodule

bind codepage_unicode_translation_table_unit cput_checker u_cput_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ tb/codepage_unicode_translation_table_unit_tb.sv @@
// Testbench for the code page to Unicode translation table: stream stimulus, prediction and checking.
module codepage_unicode_translation_table_unit_tb;
	import cput_pkg::*;

	localparam int LoadNoisePct = 12;
	localparam int RandomRequests = 450;
	localparam int DrainAt = 200;
	localparam int HoldAt = 480;
	localparam int HoldCycles = 150;
	localparam int TailCycles = 20;
	localparam int CycleLimit = 200000;

	typedef struct packed {
		logic            drain;
		logic [7:0]      lower;
		logic [KeyW-1:0] uval;
		logic [7:0]      code;
		op_t             op;
	} request_t;

	typedef struct packed {
		status_t         status;
		logic [7:0]      code;
		logic [KeyW-1:0] uni;
	} answer_t;

	logic            clk;
	logic            arst_n = 1'b0;
	logic            s_tvalid = 1'b0;
	logic            s_tready;
	logic [InW-1:0]  s_tdata = '0;
	logic            m_tvalid;
	logic            m_tready = 1'b0;
	logic [OutW-1:0] m_tdata;

	request_t        requests_to_send[$];
	answer_t         lookup_answers[$];
	logic [KeyW-1:0] gen_vals[$];

	logic [KeyW-1:0] fwd_uni[TableEntries];
	logic [7:0]      fwd_lower[TableEntries];
	logic [KeyW-1:0] rev_keys[TableEntries];
	logic [IdxW-1:0] rev_codes[TableEntries];
	int              codes_loaded;

	int sent_cnt;
	int errors;
	int cycles;
	int hold_left;
	bit hold_done;

	codepage_unicode_translation_table_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int tx_idle_pct();
		if (sent_cnt < 220) return 38;
		if (sent_cnt < 440) return 83;
		return 0;
	endfunction

	function automatic int rx_idle_pct();
		if (sent_cnt < 220) return 83;
		if (sent_cnt < 440) return 38;
		return 0;
	endfunction

	function automatic void queue_request(op_t op, logic [7:0] c, logic [KeyW-1:0] u,
			logic [7:0] lw, logic drain);
		request_t r;
		r.op = op;
		r.code = c;
		r.uval = u;
		r.lower = lw;
		r.drain = drain;
		requests_to_send.push_back(r);
	endfunction

	function automatic bit is_loaded(logic [KeyW-1:0] u);
		foreach (gen_vals[i])
			if (gen_vals[i] == u) return 1'b1;
		return 1'b0;
	endfunction

	function automatic void translate_request(logic [InW-1:0] d);
		op_t             op;
		logic [7:0]      c;
		logic [KeyW-1:0] u;
		logic [7:0]      lw;
		logic [IdxW-1:0] idx;
		answer_t         a;
		int              pos;
		int              b;
		int              w;
		op = op_t'(d[1:0]);
		c = d[9:2];
		u = d[25:10];
		lw = d[33:26];
		idx = c[IdxW-1:0];
		a.uni = '0;
		a.code = '0;
		a.status = ST_OK;
		if (op == OP_LOAD) begin
			if (codes_loaded >= TableEntries || c != CodeBase + 8'(codes_loaded)) begin
				a.status = ST_ORDER;
			end else begin
				fwd_uni[idx] = u;
				fwd_lower[idx] = lw;
				pos = 0;
				while (pos < codes_loaded && rev_keys[pos] <= u) pos++;
				for (int j = codes_loaded; j > pos; j--) begin
					rev_keys[j] = rev_keys[j-1];
					rev_codes[j] = rev_codes[j-1];
				end
				rev_keys[pos] = u;
				rev_codes[pos] = IdxW'(codes_loaded);
				codes_loaded++;
			end
		end else if (codes_loaded < TableEntries) begin
			a.status = ST_NOT_LOADED;
		end else if (op == OP_TO_UNI) begin
			a.uni = fwd_uni[idx];
		end else if (op == OP_TO_LOWER) begin
			a.code = fwd_lower[idx];
		end else begin
			b = 0;
			w = TableEntries / 2;
			while (w != 0) begin
				if (u >= rev_keys[(b + w) % TableEntries]) b += w;
				w = w / 2;
			end
			if (rev_keys[b] == u) begin
				a.code = CodeBase | 8'(rev_codes[b]);
			end else begin
				a.status = ST_NOT_FOUND;
			end
		end
		lookup_answers.push_back(a);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				translate_request(s_tdata);
				sent_cnt++;
			end
			if (!s_tvalid || s_tready) begin
				if (requests_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct()
						&& !(requests_to_send[0].drain && lookup_answers.size() != 0)) begin
					s_tvalid <= 1'b1;
					s_tdata <= {6'b0, requests_to_send[0].lower, requests_to_send[0].uval,
						requests_to_send[0].code, requests_to_send[0].op};
					void'(requests_to_send.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && sent_cnt >= HoldAt) begin
			hold_left <= HoldCycles;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		answer_t a;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (lookup_answers.size() == 0) begin
					$error("unexpected response %h", m_tdata);
					errors++;
				end else begin
					a = lookup_answers.pop_front();
					if (m_tdata[15:0] !== a.uni) begin
						$error("unicode_out: expected %h, got %h", a.uni, m_tdata[15:0]);
						errors++;
					end
					if (m_tdata[23:16] !== a.code) begin
						$error("code_out: expected %h, got %h", a.code, m_tdata[23:16]);
						errors++;
					end
					if (m_tdata[25:24] !== a.status) begin
						$error("status: expected %0d, got %0d", a.status, m_tdata[25:24]);
						errors++;
					end
				end
			end
			m_tready <= hold_left == 0 && $urandom_range(99) >= rx_idle_pct();
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("codepage_unicode_translation_table_unit_tb NOT OK");
			$finish;
		end
	end

	initial begin
		logic [KeyW-1:0] v;
		logic [7:0]      c;
		logic [7:0]      lw;
		int              r;

		// Lookups before any load, and loads out of order.
		queue_request(OP_TO_UNI, 8'hFF, 16'hFFFF, 8'hFF, 1'b0);
		queue_request(OP_TO_LOWER, 8'h00, 16'h0000, 8'h00, 1'b0);
		queue_request(OP_TO_CODE, 8'h80, 16'hFFFF, 8'h00, 1'b0);
		queue_request(OP_LOAD, CodeBase + 8'd1, 16'h1234, 8'h55, 1'b0);
		queue_request(OP_LOAD, 8'h00, 16'h0000, 8'h00, 1'b0);

		// In-order loads with some duplicate values, mixed with noise.
		for (int k = 0; k < TableEntries; k++) begin
			while ($urandom_range(99) < LoadNoisePct) begin
				if ($urandom_range(1) == 0) begin
					c = 8'($urandom);
					if (c == CodeBase + 8'(k)) c = c ^ 8'h01;
					queue_request(OP_LOAD, c, 16'($urandom), 8'($urandom), 1'b0);
				end else begin
					queue_request(op_t'($urandom_range(1, 3)), 8'($urandom), 16'($urandom),
						8'($urandom), 1'b0);
				end
			end
			if (k == TableEntries - 1)
				queue_request(OP_TO_CODE, CodeBase, gen_vals[0], 8'h00, 1'b0);
			if (k == 0)
				v = 16'h0000;
			else if (k == TableEntries - 1)
				v = 16'hFFFF;
			else if ($urandom_range(3) == 0)
				v = gen_vals[$urandom_range(k - 1)];
			else
				v = 16'($urandom);
			if (k == 0)
				lw = 8'h00;
			else if (k == TableEntries - 1)
				lw = 8'hFF;
			else
				lw = 8'($urandom);
			queue_request(OP_LOAD, CodeBase + 8'(k), v, lw, 1'b0);
			gen_vals.push_back(v);
		end

		// Full table: late loads, edge codes, aliased low codes, hits, duplicates, a miss.
		queue_request(OP_LOAD, CodeBase, 16'h0001, 8'h01, 1'b0);
		queue_request(OP_LOAD, 8'h00, 16'h0000, 8'h00, 1'b0);
		queue_request(OP_TO_UNI, 8'h80, 16'h0000, 8'h00, 1'b0);
		queue_request(OP_TO_UNI, 8'hFF, 16'h0000, 8'h00, 1'b0);
		queue_request(OP_TO_UNI, 8'h00, 16'h0000, 8'h00, 1'b0);
		queue_request(OP_TO_UNI, 8'h7F, 16'h0000, 8'h00, 1'b0);
		queue_request(OP_TO_LOWER, 8'h80, 16'h0000, 8'h00, 1'b0);
		queue_request(OP_TO_LOWER, 8'hFF, 16'h0000, 8'h00, 1'b0);
		queue_request(OP_TO_LOWER, 8'h05, 16'h0000, 8'h00, 1'b0);
		queue_request(OP_TO_CODE, 8'h00, 16'h0000, 8'h00, 1'b0);
		queue_request(OP_TO_CODE, 8'h00, 16'hFFFF, 8'h00, 1'b0);
		queue_request(OP_TO_CODE, 8'h00, gen_vals[64], 8'h00, 1'b0);
		do v = 16'($urandom); while (is_loaded(v));
		queue_request(OP_TO_CODE, 8'h00, v, 8'h00, 1'b0);

		for (int i = 0; i < RandomRequests; i++) begin
			r = $urandom_range(99);
			v = 16'($urandom);
			if (r < 8) begin
				queue_request(OP_LOAD, 8'($urandom), v, 8'($urandom), i == DrainAt);
			end else if (r < 30) begin
				queue_request(OP_TO_UNI, 8'($urandom), v, 8'($urandom), i == DrainAt);
			end else if (r < 50) begin
				queue_request(OP_TO_LOWER, 8'($urandom), v, 8'($urandom), i == DrainAt);
			end else begin
				if ($urandom_range(9) < 6) v = gen_vals[$urandom_range(TableEntries - 1)];
				queue_request(OP_TO_CODE, 8'($urandom), v, 8'($urandom), i == DrainAt);
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (requests_to_send.size() != 0 || s_tvalid) @(posedge clk);
		while (lookup_answers.size() != 0) @(posedge clk);
		repeat (TailCycles) @(posedge clk);

		if (errors == 0 && lookup_answers.size() == 0) begin
			$display("codepage_unicode_translation_table_unit_tb OK");
		end else begin
			$display("codepage_unicode_translation_table_unit_tb NOT OK");
		end
		$finish;
	end

endmodule
